// ===== hdl/timer_lcd_serial_io_registers_top_defines.svh =====
// Assertion macros shared by the I/O register block.
// Included by modules that carry concurrent assertions.
`ifndef TIMER_LCD_SERIAL_IO_REGISTERS_TOP_DEFINES_SVH
`define TIMER_LCD_SERIAL_IO_REGISTERS_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TLS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define TLS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hdl/tlsio_pkg.sv =====
// Shared types and constants for the I/O register block.
// No dependencies.
package tlsio_pkg;
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [15:0] A_P1   = 16'hFF00;
  localparam logic [15:0] A_SB   = 16'hFF01;
  localparam logic [15:0] A_SC   = 16'hFF02;
  localparam logic [15:0] A_DIV  = 16'hFF04;
  localparam logic [15:0] A_TIMA = 16'hFF05;
  localparam logic [15:0] A_TMA  = 16'hFF06;
  localparam logic [15:0] A_TAC  = 16'hFF07;
  localparam logic [15:0] A_IF   = 16'hFF0F;
  localparam logic [15:0] A_LCDC = 16'hFF40;
  localparam logic [15:0] A_STAT = 16'hFF41;
  localparam logic [15:0] A_SCY  = 16'hFF42;
  localparam logic [15:0] A_SCX  = 16'hFF43;
  localparam logic [15:0] A_LY   = 16'hFF44;
  localparam logic [15:0] A_LYC  = 16'hFF45;
  localparam logic [15:0] A_BGP  = 16'hFF47;
  localparam logic [15:0] A_OBP0 = 16'hFF48;
  localparam logic [15:0] A_OBP1 = 16'hFF49;
  localparam logic [15:0] A_WY   = 16'hFF4A;
  localparam logic [15:0] A_WX   = 16'hFF4B;
  localparam logic [15:0] A_IE   = 16'hFFFF;

  localparam logic [7:0] LINE_VBLANK = 8'd144;
  localparam logic [7:0] LINE_WRAP   = 8'd154;
  localparam int         MODE2_END   = 80;
  localparam int         MODE3_END   = 252;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_LINE, ST_SERIAL, ST_OUT
  } tls_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic exec;      // timer, divider, register access
    logic line_step; // one line wrap
    logic serial;    // serial countdown and result finish
  } tls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_pending;
  } tls_sts_t;

  function automatic logic [3:0] sel_bit(input logic [1:0] tac);
    case (tac)
      2'd0: sel_bit = 4'd9;
      2'd1: sel_bit = 4'd3;
      2'd2: sel_bit = 4'd5;
      default: sel_bit = 4'd7;
    endcase
  endfunction
endpackage

// ===== hdl/tlsio_ctrl.sv =====
// Sequencer for the I/O register block: load, execute, line wraps, serial, output.
// Depends on tlsio_pkg and timer_lcd_serial_io_registers_top_defines.svh.
`include "timer_lcd_serial_io_registers_top_defines.svh"
module tlsio_ctrl import tlsio_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  tls_sts_t sts,
  output tls_cmd_t cmd
);
  tls_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = ST_LINE;
      ST_LINE:   if (!sts.line_pending) state_nxt = ST_SERIAL;
      ST_SERIAL: state_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) state_nxt = in_valid ? ST_EXEC : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EXEC:   cmd.exec = 1'b1;
      ST_LINE:   cmd.line_step = sts.line_pending;
      ST_SERIAL: cmd.serial = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        in_stall = out_stall;
        cmd.load = in_valid && !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  `TLS_ASSERT_IMP(a_load_only_open, clk, rst_n, cmd.load, !in_stall && in_valid)
  `TLS_ASSERT_NXT(a_load_exec, clk, rst_n, cmd.load, state_r == ST_EXEC)
  `TLS_ASSERT_IMP(a_out_no_accept, clk, rst_n, out_valid && out_stall, in_stall)
endmodule

// ===== hdl/tlsio_dp.sv =====
// Datapath: divider, timer, LCD line counter, serial countdown and registers.
// Depends on tlsio_pkg.
module tlsio_dp import tlsio_pkg::*; #(
  parameter int CYCLES_PER_LINE = 456,
  parameter int SERIAL_TRANSFER_CYCLES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  tls_cmd_t   cmd,
  output tls_sts_t   sts,
  input  logic [1:0] in_op,
  input  logic [15:0] in_addr,
  input  logic [7:0] in_wdata,
  input  logic [9:0] in_cycles,
  output logic [7:0] out_rdata,
  output logic [4:0] out_int_flags,
  output logic       out_serial_start,
  output logic [7:0] out_serial_byte
);
  localparam logic [10:0] CPL = 11'(CYCLES_PER_LINE);

  logic [1:0]  op_r;
  logic [15:0] addr_r;
  logic [7:0]  wdata_r;
  logic [9:0]  cyc_r;
  logic [15:0] div_r;
  logic [7:0]  tima_r, tma_r, ie_r, p1_r, sb_r, sc_r, lcdc_r, stat_r, ly_r, lyc_r;
  logic [2:0]  tac_r;
  logic [4:0]  if_r;
  logic        ser_busy_r;
  logic [13:0] ser_rem_r;
  logic [11:0] lcyc_r;
  logic [7:0]  spw_r [7];
  logic [7:0]  rdata_r, sbyte_r;
  logic        start_r;

  logic [15:0] div_sum;
  logic        fell;
  logic [7:0]  tima_inc;
  logic [7:0]  ly_inc, ly_new;
  logic [1:0]  mode;
  logic [7:0]  rd;
  logic [2:0]  spw_idx;
  logic        spw_hit;
  logic [14:0] ser_diff;
  logic        is_tick, is_wr;

  assign is_tick = (op_r == OP_TICK);
  assign is_wr = (op_r == OP_WRITE);
  assign div_sum = div_r + {6'd0, cyc_r};
  assign tima_inc = tima_r + 8'd1;
  assign sts.line_pending = (lcyc_r >= {1'b0, CPL});
  assign ly_inc = ly_r + 8'd1;
  assign ly_new = (ly_inc >= LINE_WRAP) ? 8'd0 : ly_inc;
  assign ser_diff = {1'b0, ser_rem_r} - {5'd0, cyc_r};

  // timer edge: selected bit falls on a tick, or is set on a DIV write
  always_comb begin
    if (is_tick) fell = div_r[sel_bit(tac_r[1:0])] && !div_sum[sel_bit(tac_r[1:0])];
    else fell = (addr_r == A_DIV) && div_r[sel_bit(tac_r[1:0])];
    fell = fell && tac_r[2] && (is_tick || is_wr);
  end

  // decode palette/scroll addresses
  always_comb begin
    spw_hit = 1'b1;
    spw_idx = 3'd0;
    unique case (addr_r)
      A_SCY:  spw_idx = 3'd0;
      A_SCX:  spw_idx = 3'd1;
      A_BGP:  spw_idx = 3'd2;
      A_OBP0: spw_idx = 3'd3;
      A_OBP1: spw_idx = 3'd4;
      A_WY:   spw_idx = 3'd5;
      A_WX:   spw_idx = 3'd6;
      default: spw_hit = 1'b0;
    endcase
  end

  // read mux
  always_comb begin
    mode = 2'd0;
    if (lcdc_r[7]) begin
      if (ly_r >= LINE_VBLANK) mode = 2'd1;
      else if (lcyc_r < 12'(MODE2_END)) mode = 2'd2;
      else if (lcyc_r < 12'(MODE3_END)) mode = 2'd3;
    end
    if (spw_hit) rd = spw_r[spw_idx];
    else begin
      unique case (addr_r)
        A_IE:   rd = ie_r;
        A_P1:   rd = p1_r | 8'hCF;
        A_SB:   rd = sb_r;
        A_SC:   rd = sc_r | 8'h7E;
        A_DIV:  rd = div_r[15:8];
        A_TIMA: rd = tima_r;
        A_TMA:  rd = tma_r;
        A_TAC:  rd = {5'h1F, tac_r};
        A_IF:   rd = {3'h7, if_r};
        A_LCDC: rd = lcdc_r;
        A_STAT: rd = (stat_r & 8'hFC) | {6'd0, mode} | 8'h80;
        A_LY:   rd = ly_r;
        A_LYC:  rd = lyc_r;
        default: rd = 8'hFF;
      endcase
    end
  end

  // capture input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      addr_r <= in_addr;
      wdata_r <= in_wdata;
      cyc_r <= in_cycles;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0; tima_r <= '0; tma_r <= '0; tac_r <= '0; if_r <= '0;
      ie_r <= '0; p1_r <= '0; sb_r <= '0; sc_r <= '0; ser_busy_r <= 1'b0;
      ser_rem_r <= '0; lcdc_r <= '0; stat_r <= '0; ly_r <= '0; lyc_r <= '0;
      lcyc_r <= '0; start_r <= 1'b0; rdata_r <= '0; sbyte_r <= '0;
      for (int i = 0; i < 7; i++) spw_r[i] <= '0;
    end else begin
      if (cmd.exec) begin
        rdata_r <= (op_r == OP_READ) ? rd : 8'd0;
        start_r <= 1'b0;
        sbyte_r <= 8'd0;
        if (fell) begin
          if (tima_inc == 8'd0) begin
            tima_r <= tma_r;
            if_r[2] <= 1'b1;
          end else tima_r <= tima_inc;
        end
        if (is_tick) begin
          div_r <= div_sum;
          if (lcdc_r[7]) lcyc_r <= lcyc_r + {2'd0, cyc_r};
        end
        if (is_wr) begin
          if (spw_hit) spw_r[spw_idx] <= wdata_r;
          else begin
            case (addr_r)
              A_IE: ie_r <= wdata_r;
              A_P1: p1_r <= wdata_r & 8'h30;
              A_SB: sb_r <= wdata_r;
              A_SC: begin
                sc_r <= wdata_r;
                if (wdata_r[7] && wdata_r[0]) begin
                  ser_busy_r <= 1'b1;
                  ser_rem_r <= 14'(SERIAL_TRANSFER_CYCLES);
                  start_r <= 1'b1;
                  sbyte_r <= sb_r;
                end
              end
              A_DIV:  div_r <= '0;
              A_TIMA: if (!fell) tima_r <= wdata_r;
              A_TMA:  tma_r <= wdata_r;
              A_TAC:  tac_r <= wdata_r[2:0];
              A_IF:   if_r <= wdata_r[4:0];
              A_LCDC: begin
                if (lcdc_r[7] && !wdata_r[7]) begin
                  ly_r <= '0;
                  lcyc_r <= '0;
                end
                lcdc_r <= wdata_r;
              end
              A_STAT: stat_r <= (wdata_r & 8'h78) | (stat_r & 8'h07);
              A_LYC:  lyc_r <= wdata_r;
              default: ;
            endcase
          end
        end
      end
      // advance one line
      if (cmd.line_step) begin
        lcyc_r <= lcyc_r - {1'b0, CPL};
        ly_r <= ly_new;
        if (ly_inc == LINE_VBLANK) if_r[0] <= 1'b1;
        stat_r[2] <= (ly_new == lyc_r);
        if ((ly_new == lyc_r) && stat_r[6]) if_r[1] <= 1'b1;
      end
      // serial countdown
      if (cmd.serial && is_tick && ser_busy_r) begin
        if (ser_diff[14]) begin
          ser_busy_r <= 1'b0;
          sc_r[7] <= 1'b0;
          if_r[3] <= 1'b1;
        end else ser_rem_r <= ser_diff[13:0];
      end
    end
  end

  assign out_rdata = rdata_r;
  assign out_int_flags = if_r;
  assign out_serial_start = start_r;
  assign out_serial_byte = sbyte_r;
endmodule

// ===== hdl/timer_lcd_serial_io_registers_top.sv =====
// Top level of the I/O register block: divider/timer, LCD line, serial, IRQ.
// Depends on tlsio_pkg, tlsio_ctrl and tlsio_dp.
//
// Usage: one input channel (in_valid/in_stall) carries op, addr, wdata and
// cycles; one output channel (out_valid/out_stall) returns rdata, int_flags,
// serial_start and serial_byte, one result beat per input beat, in order.
// For reads, writes and ticks with no line wrap, an item passes after its
// input beat through execute, line check, serial countdown and output. Each
// LCD line wrap in a tick is taken one wrap at a time by the shared line-step
// unit in the line-check state (up to three wraps).
// The next input beat is taken in the same cycle the result beat leaves,
// so no new item is taken before the last one's result beat has left.
// Synchronous active-low reset clears all state registers but the input
// capture registers; the serial countdown resets idle. While the receiver
// stalls, the result holds and no new input beat is taken.
module timer_lcd_serial_io_registers_top import tlsio_pkg::*; #(
  parameter int CYCLES_PER_LINE = 456,
  parameter int SERIAL_TRANSFER_CYCLES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_wdata,
  input  logic [9:0]  in_cycles,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_rdata,
  output logic [4:0]  out_int_flags,
  output logic        out_serial_start,
  output logic [7:0]  out_serial_byte
);
  tls_cmd_t cmd;
  tls_sts_t sts;

  tlsio_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  tlsio_dp #(
    .CYCLES_PER_LINE(CYCLES_PER_LINE),
    .SERIAL_TRANSFER_CYCLES(SERIAL_TRANSFER_CYCLES)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_op, .in_addr, .in_wdata, .in_cycles,
    .out_rdata, .out_int_flags, .out_serial_start, .out_serial_byte
  );
endmodule

// ===== tb/tb_timer_lcd_serial_io_registers_top.sv =====
`timescale 1ns / 1ps
// Testbench for the I/O register block: timer, divider, LCD line, serial and IRQ.
// Predicts each result beat in step with the input and compares field by field.
// Depends on tlsio_pkg and timer_lcd_serial_io_registers_top.
module tb_timer_lcd_serial_io_registers_top;
  import tlsio_pkg::*;

  localparam int LINE_CYC = 456;
  localparam int XFER_CYC = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [7:0] rdata;
    logic [4:0] flags;
    logic       sstart;
    logic [7:0] sbyte;
  } io_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic [15:0] in_addr = '0;
  logic [7:0] in_wdata = '0;
  logic [9:0] in_cycles = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_rdata;
  logic [4:0] out_int_flags;
  logic out_serial_start;
  logic [7:0] out_serial_byte;

  // shadow copy of the register file
  logic [15:0] div_q;
  logic [7:0]  tima_q, tma_q;
  logic [2:0]  tac_q;
  logic [4:0]  if_q;
  logic [7:0]  ie_q, p1_q, sb_q, sc_q, lcdc_q, stat_q, ly_q, lyc_q;
  int          serial_left;
  int          line_pos;
  logic [7:0]  spw_q [7];

  io_result_t expected_q [$];
  int errors = 0;
  int cycle_count = 0;
  bit rx_idle_ok = 1'b1;
  bit tx_idle_ok = 1'b1;
  bit hold_rx = 1'b0;

  always #10 clk = ~clk;

  timer_lcd_serial_io_registers_top i_dut (.*);

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_timer_lcd_serial_io_registers_top: done, errors");
      $finish;
    end
  end

  function automatic int spw_slot(logic [15:0] a);
    case (a)
      A_SCY: return 0;
      A_SCX: return 1;
      A_BGP: return 2;
      A_OBP0: return 3;
      A_OBP1: return 4;
      A_WY: return 5;
      A_WX: return 6;
      default: return -1;
    endcase
  endfunction

  function automatic logic div_tap(logic [15:0] d);
    logic [3:0] b;
    case (tac_q[1:0])
      2'd0: b = 4'd9;
      2'd1: b = 4'd3;
      2'd2: b = 4'd5;
      default: b = 4'd7;
    endcase
    return d[b];
  endfunction

  function automatic void bump_timer();
    tima_q = tima_q + 8'd1;
    if (tima_q == 8'd0) begin
      tima_q = tma_q;
      if_q[2] = 1'b1;
    end
  endfunction

  task automatic reset_shadow();
    div_q = '0; tima_q = '0; tma_q = '0; tac_q = '0; if_q = '0; ie_q = '0;
    p1_q = '0; sb_q = '0; sc_q = '0; lcdc_q = '0; stat_q = '0; ly_q = '0;
    lyc_q = '0; serial_left = -1; line_pos = 0;
    foreach (spw_q[i]) spw_q[i] = '0;
  endtask

  // compute the result beat for one accepted item
  function automatic io_result_t predict_io(logic [1:0] op, logic [15:0] a,
                                            logic [7:0] v, logic [9:0] cyc);
    io_result_t r;
    logic [15:0] old_div;
    logic [1:0] mode;
    int k;
    r = '0;
    k = spw_slot(a);
    if (op == OP_TICK) begin
      old_div = div_q;
      div_q = div_q + 16'(cyc);
      if (tac_q[2] && div_tap(old_div) && !div_tap(div_q)) bump_timer();
      if (lcdc_q[7]) begin
        line_pos += cyc;
        while (line_pos >= LINE_CYC) begin
          line_pos -= LINE_CYC;
          ly_q = ly_q + 8'd1;
          if (ly_q == LINE_VBLANK) if_q[0] = 1'b1;
          if (ly_q >= LINE_WRAP) ly_q = 8'd0;
          stat_q[2] = (ly_q == lyc_q);
          if (stat_q[2] && stat_q[6]) if_q[1] = 1'b1;
        end
      end
      if (serial_left >= 0) begin
        serial_left -= cyc;
        if (serial_left < 0) begin
          serial_left = -1;
          sc_q[7] = 1'b0;
          if_q[3] = 1'b1;
        end
      end
    end else if (op == OP_READ) begin
      if (k >= 0) r.rdata = spw_q[k];
      else case (a)
        A_IE: r.rdata = ie_q;
        A_P1: r.rdata = p1_q | 8'hCF;
        A_SB: r.rdata = sb_q;
        A_SC: r.rdata = sc_q | 8'h7E;
        A_DIV: r.rdata = div_q[15:8];
        A_TIMA: r.rdata = tima_q;
        A_TMA: r.rdata = tma_q;
        A_TAC: r.rdata = {5'h1F, tac_q};
        A_IF: r.rdata = {3'b111, if_q};
        A_LCDC: r.rdata = lcdc_q;
        A_STAT: begin
          mode = 2'd0;
          if (lcdc_q[7]) begin
            if (ly_q >= LINE_VBLANK) mode = 2'd1;
            else if (line_pos < MODE2_END) mode = 2'd2;
            else if (line_pos < MODE3_END) mode = 2'd3;
          end
          r.rdata = (stat_q & 8'hFC) | mode | 8'h80;
        end
        A_LY: r.rdata = ly_q;
        A_LYC: r.rdata = lyc_q;
        default: r.rdata = 8'hFF;
      endcase
    end else if (op == OP_WRITE) begin
      if (k >= 0) spw_q[k] = v;
      else case (a)
        A_IE: ie_q = v;
        A_P1: p1_q = v & 8'h30;
        A_SB: sb_q = v;
        A_SC: begin
          sc_q = v;
          if (v[7] && v[0]) begin
            serial_left = XFER_CYC;
            r.sstart = 1'b1;
            r.sbyte = sb_q;
          end
        end
        A_DIV: begin
          old_div = div_q;
          div_q = '0;
          if (tac_q[2] && div_tap(old_div)) bump_timer();
        end
        A_TIMA: tima_q = v;
        A_TMA: tma_q = v;
        A_TAC: tac_q = v[2:0];
        A_IF: if_q = v[4:0];
        A_LCDC: begin
          if (lcdc_q[7] && !v[7]) begin
            ly_q = '0;
            line_pos = 0;
          end
          lcdc_q = v;
        end
        A_STAT: stat_q = (v & 8'h78) | (stat_q & 8'h07);
        A_LYC: lyc_q = v;
        default: ;
      endcase
    end
    r.flags = if_q;
    return r;
  endfunction

  // check every result beat against the oldest prediction
  always @(posedge clk) begin
    io_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_rdata, out_int_flags, out_serial_start, out_serial_byte};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.rdata !== want.rdata) begin
          $display("%0t: rdata expected %h actual %h", $time, want.rdata, got.rdata);
          errors++;
        end
        if (got.flags !== want.flags) begin
          $display("%0t: int_flags expected %h actual %h", $time, want.flags, got.flags);
          errors++;
        end
        if (got.sstart !== want.sstart) begin
          $display("%0t: serial_start expected %b actual %b", $time, want.sstart,
                   got.sstart);
          errors++;
        end
        if (got.sbyte !== want.sbyte) begin
          $display("%0t: serial_byte expected %h actual %h", $time, want.sbyte,
                   got.sbyte);
          errors++;
        end
      end
    end
  end

  // receiver stall: random bursts, or a long hold when asked
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_rx = 1'b0;
      end else if (rx_idle_ok && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one beat and hold it until taken; valid stays up into the next beat
  task automatic send_item(logic [1:0] op, logic [15:0] a, logic [7:0] v,
                           logic [9:0] cyc);
    if (tx_idle_ok && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    expected_q.insert(expected_q.size(), predict_io(op, a, v, cyc));
    in_valid <= 1'b1;
    in_op <= op;
    in_addr <= a;
    in_wdata <= v;
    in_cycles <= cyc;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic test_directed();
    send_item(OP_READ, A_LY, 8'h00, 10'd0);
    send_item(OP_WRITE, A_TAC, 8'hFF, 10'd0);
    send_item(OP_WRITE, A_TIMA, 8'hFF, 10'd0);
    send_item(OP_WRITE, A_TMA, 8'hA5, 10'd0);
    send_item(OP_TICK, 16'h0000, 8'h00, 10'd1023);
    send_item(OP_TICK, 16'hFFFF, 8'hFF, 10'd0);
    send_item(OP_WRITE, A_DIV, 8'h00, 10'd0);
    send_item(OP_WRITE, A_LCDC, 8'h80, 10'd0);
    send_item(OP_WRITE, A_STAT, 8'hFF, 10'd0);
    send_item(OP_WRITE, A_LYC, 8'h02, 10'd0);
    send_item(OP_TICK, 16'h0000, 8'h00, 10'd1023);
    send_item(OP_READ, A_STAT, 8'h00, 10'd0);
    send_item(OP_WRITE, A_LY, 8'h55, 10'd0);
    send_item(OP_WRITE, A_SB, 8'h3C, 10'd0);
    send_item(OP_WRITE, A_SC, 8'h81, 10'd0);
    send_item(OP_UNDEF, A_SC, 8'hFF, 10'd1023);
    repeat (5) send_item(OP_TICK, 16'h0000, 8'h00, 10'd1023);
    send_item(OP_READ, A_SC, 8'h00, 10'd0);
    send_item(OP_READ, 16'hFF46, 8'h00, 10'd0);
    send_item(OP_WRITE, A_LCDC, 8'h00, 10'd0);
    send_item(OP_READ, A_IF, 8'h00, 10'd0);
    send_item(OP_WRITE, A_IF, 8'h00, 10'd0);
  endtask

  function automatic logic [15:0] pick_addr();
    logic [15:0] mapped [21] = '{A_P1, A_SB, A_SC, A_DIV, A_TIMA, A_TMA, A_TAC,
      A_IF, A_LCDC, A_STAT, A_SCY, A_SCX, A_LY, A_LYC, A_BGP, A_OBP0, A_OBP1,
      A_WY, A_WX, A_IE, 16'hFF10};
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    if ($urandom_range(0, 9) == 0) return 16'hFF00 | 16'($urandom_range(0, 8'h4F));
    return mapped[$urandom_range(0, 20)];
  endfunction

  // ticks, reads and writes, ticks most often; LCD kept on most of the time
  task automatic test_random(int count, bit with_hold);
    logic [1:0] op;
    logic [15:0] a;
    logic [7:0] v;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 2) hold_rx = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = OP_TICK;
        4, 5, 6: op = OP_READ;
        7, 8: op = OP_WRITE;
        default: op = 2'($urandom);
      endcase
      a = pick_addr();
      v = 8'($urandom);
      if (op == OP_WRITE && a == A_LCDC && $urandom_range(0, 3) != 0) v[7] = 1'b1;
      if (op == OP_WRITE && a == A_DIV && $urandom_range(0, 3) != 0) a = A_TAC;
      send_item(op, a, v, 10'($urandom));
    end
  endtask

  task automatic test_no_idle();
    rx_idle_ok = 1'b0;
    tx_idle_ok = 1'b0;
    test_random(300, 1'b0);
  endtask

  initial begin
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1700, 1'b1);
    test_no_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("tb_timer_lcd_serial_io_registers_top: done, clean");
    else
      $display("tb_timer_lcd_serial_io_registers_top: done, errors");
    $finish;
  end
endmodule
